FILE: rtl/krt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// krt_pkg
// Shared types and codes for the keyed record table.
// ---------------------------------------------------------------------------
package krt_pkg;

   // Number of records the table can hold.
   localparam int CAPACITY = 256;

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_MODIFY = 3'd1,
      OP_REMOVE = 3'd2,
      OP_FIND   = 3'd3,
      OP_SORT   = 3'd4,
      OP_CLEAR  = 3'd5,
      OP_BAD6   = 3'd6,
      OP_BAD7   = 3'd7
   } op_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_MISS    = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

   localparam logic CSR_INITIAL_SIZE = 1'b0;
   localparam logic CSR_GROW_STEP    = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LIN_RD,
      S_LIN_CMP,
      S_BIN_RD,
      S_BIN_CMP,
      S_ACT_RD,
      S_ACT_WR,
      S_SRT_RDI,
      S_SRT_KI,
      S_SRT_RDJ,
      S_SRT_CMP,
      S_SRT_PUT,
      S_DONE
   } state_type;

endpackage : krt_pkg
`default_nettype wire

FILE: rtl/krt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// krt_ram
// Generic single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module krt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One access a cycle: write or registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule : krt_ram
`default_nettype wire

FILE: rtl/keyed_record_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// keyed_record_table
// Table of key and count records with search, edit, sort and clear.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy stays high
// until the single response strobe, which the receiver cannot hold off.
// Keys and counts live in one single-port RAM entry per record, so every
// probe takes an address state and then a compare on the registered data.
// A search walks linearly while the table is unsorted and is binary once
// it is sorted; an add or a remove has an extra write state, and each sort
// insertion step reads and writes through the same port. Clear and invalid
// requests go straight to the done state. No clearing pass is needed.
module keyed_record_table
   import krt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [2:0]  req_operation,
   input  wire logic [31:0] req_key,
   input  wire logic [15:0] req_fail_count,
   output      logic        rsp_valid,
   output      logic [1:0]  rsp_status,
   output      logic [15:0] rsp_found_count,
   output      logic [8:0]  rsp_entry_total,
   output      logic [8:0]  rsp_size_now,
   output      logic [15:0] rsp_comparison_count,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [8:0]  csr_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = AW + 1;
   localparam int DW = 48;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [31:0] key_ff, key_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [CW-1:0] count_ff, count_in, size_ff, size_in;
   logic [CW-1:0] init_ff, init_in, step_ff, step_in;
   logic        sorted_ff, sorted_in;
   logic [CW:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] idx_ff, idx_in, jdx_ff, jdx_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic        hit_ff, hit_in;
   logic [DW-1:0] hold_ff, hold_in;
   logic [16:0] cmp_ff, cmp_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] found_ff, found_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [DW-1:0] ram_wdata, ram_rdata;
   logic [31:0]   rd_key;
   logic [CW:0]   mid;
   logic [CW-1:0] step_eff, reg_clamp;
   logic [CW:0]   grow_sum;

   krt_ram #(.WIDTH(DW), .DEPTH(CAPACITY)) u_store (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   assign rd_key = ram_rdata[DW-1:16];
   assign mid    = (lo_ff + hi_ff) >> 1;

   // Clamp register values to capacity, with a zero step acting as one.
   always_comb begin
      reg_clamp = (int'(csr_data) > CAPACITY) ? CW'(CAPACITY) : CW'(csr_data);
      step_eff  = (step_ff == '0) ? CW'(1) : step_ff;
      grow_sum  = {1'b0, size_ff} + {1'b0, step_eff};
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         size_ff   <= CW'(16 > CAPACITY ? CAPACITY : 16);
         init_ff   <= CW'(16 > CAPACITY ? CAPACITY : 16);
         step_ff   <= CW'(16 > CAPACITY ? CAPACITY : 16);
         sorted_ff <= 1'b1;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         size_ff   <= size_in;
         init_ff   <= init_in;
         step_ff   <= step_in;
         sorted_ff <= sorted_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      cnt_ff    <= cnt_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      jdx_ff    <= jdx_in;
      pos_ff    <= pos_in;
      hit_ff    <= hit_in;
      hold_ff   <= hold_in;
      cmp_ff    <= cmp_in;
      status_ff <= status_in;
      found_ff  <= found_in;
   end

   // Next state and datapath.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      cnt_in    = cnt_ff;
      count_in  = count_ff;
      size_in   = size_ff;
      init_in   = init_ff;
      step_in   = step_ff;
      sorted_in = sorted_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      idx_in    = idx_ff;
      jdx_in    = jdx_ff;
      pos_in    = pos_ff;
      hit_in    = hit_ff;
      hold_in   = hold_ff;
      cmp_in    = cmp_ff;
      status_in = status_ff;
      found_in  = found_ff;
      ram_we    = 1'b0;
      ram_addr  = '0;
      ram_wdata = '0;

      // Configuration writes.
      if (csr_write) begin
         if (csr_index == CSR_INITIAL_SIZE) begin
            init_in = reg_clamp;
            if (count_ff == '0) begin
               size_in = reg_clamp;
            end
         end else begin
            step_in = reg_clamp;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = op_type'(req_operation);
               key_in    = req_key;
               cnt_in    = req_fail_count;
               cmp_in    = '0;
               status_in = ST_OK;
               found_in  = '0;
               hit_in    = 1'b0;
               lo_in     = '0;
               hi_in     = {1'b0, count_ff} - 1'b1;
               idx_in    = '0;
               unique case (op_type'(req_operation))
                  OP_ADD, OP_MODIFY: begin
                     if (req_key == '0 || req_fail_count == '0) begin
                        status_in = ST_INVALID;
                        state_in  = S_DONE;
                     end else begin
                        state_in = sorted_ff ? S_BIN_RD : S_LIN_RD;
                     end
                  end
                  OP_REMOVE, OP_FIND: state_in = sorted_ff ? S_BIN_RD : S_LIN_RD;
                  OP_SORT: begin
                     idx_in   = CW'(1);
                     state_in = S_SRT_RDI;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     size_in  = '0;
                     state_in = S_DONE;
                  end
                  default: begin
                     status_in = ST_INVALID;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         // Linear walk: address entry idx, then compare.
         S_LIN_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_ACT_RD;
            end else begin
               ram_addr = idx_ff[AW-1:0];
               state_in = S_LIN_CMP;
            end
         end
         S_LIN_CMP: begin
            cmp_in = cmp_ff + 1'b1;
            if (rd_key == key_ff) begin
               hit_in   = 1'b1;
               pos_in   = idx_ff[AW-1:0];
               found_in = ram_rdata[15:0];
               state_in = S_ACT_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_LIN_RD;
            end
         end
         // Binary search over signed lo and hi bounds.
         S_BIN_RD: begin
            if ($signed(lo_ff) > $signed(hi_ff)) begin
               state_in = S_ACT_RD;
            end else begin
               ram_addr = mid[AW-1:0];
               state_in = S_BIN_CMP;
            end
         end
         S_BIN_CMP: begin
            if (rd_key == key_ff) begin
               cmp_in   = cmp_ff + 1'b1;
               hit_in   = 1'b1;
               pos_in   = mid[AW-1:0];
               found_in = ram_rdata[15:0];
               state_in = S_ACT_RD;
            end else begin
               cmp_in = cmp_ff + 17'd2;
               if (rd_key > key_ff) begin
                  hi_in = mid - 1'b1;
               end else begin
                  lo_in = mid + 1'b1;
               end
               state_in = S_BIN_RD;
            end
         end
         // Apply the edit; add and remove first read the last entry.
         S_ACT_RD: begin
            state_in = S_DONE;
            // Only a find reports the stored count.
            if (op_ff != OP_FIND) begin
               found_in = '0;
            end
            priority case (op_ff)
               OP_ADD: begin
                  if (hit_ff || count_ff >= CW'(CAPACITY)) begin
                     status_in = ST_MISS;
                  end else if (count_ff != '0) begin
                     ram_addr = AW'(count_ff - 1'b1);
                     state_in = S_ACT_WR;
                  end else begin
                     state_in = S_ACT_WR;
                  end
               end
               OP_MODIFY: begin
                  if (!hit_ff) begin
                     status_in = ST_MISS;
                  end else begin
                     ram_we    = 1'b1;
                     ram_addr  = pos_ff;
                     ram_wdata = {key_ff, cnt_ff};
                  end
               end
               OP_REMOVE: begin
                  if (!hit_ff) begin
                     status_in = ST_MISS;
                  end else begin
                     ram_addr = AW'(count_ff - 1'b1);
                     state_in = S_ACT_WR;
                  end
               end
               OP_FIND: begin
                  if (!hit_ff) begin
                     status_in = ST_MISS;
                     found_in  = '0;
                  end
               end
               default: ;
            endcase
         end
         S_ACT_WR: begin
            state_in = S_DONE;
            found_in = '0;
            if (op_ff == OP_ADD) begin
               if (count_ff != '0 && key_ff < rd_key) begin
                  sorted_in = 1'b0;
               end
               if (count_ff >= size_ff) begin
                  size_in = (grow_sum > (CW+1)'(CAPACITY)) ? CW'(CAPACITY)
                                                          : grow_sum[CW-1:0];
               end
               ram_we    = 1'b1;
               ram_addr  = count_ff[AW-1:0];
               ram_wdata = {key_ff, cnt_ff};
               count_in  = count_ff + 1'b1;
            end else begin
               ram_we    = 1'b1;
               ram_addr  = pos_ff;
               ram_wdata = ram_rdata;
               count_in  = count_ff - 1'b1;
               if (size_ff >= count_in && size_ff - count_in >= step_eff) begin
                  size_in = size_ff - step_eff;
               end
               sorted_in = 1'b0;
            end
         end
         // Insertion sort: hold entry i, shift larger entries up.
         S_SRT_RDI: begin
            if (idx_ff >= count_ff) begin
               sorted_in = 1'b1;
               state_in  = S_DONE;
            end else begin
               ram_addr = idx_ff[AW-1:0];
               state_in = S_SRT_KI;
            end
         end
         S_SRT_KI: begin
            hold_in  = ram_rdata;
            jdx_in   = idx_ff;
            state_in = S_SRT_RDJ;
         end
         S_SRT_RDJ: begin
            if (jdx_ff == '0) begin
               state_in = S_SRT_PUT;
            end else begin
               ram_addr = AW'(jdx_ff - 1'b1);
               state_in = S_SRT_CMP;
            end
         end
         S_SRT_CMP: begin
            cmp_in = cmp_ff + 1'b1;
            if (ram_rdata[DW-1:16] > hold_ff[DW-1:16]) begin
               ram_we    = 1'b1;
               ram_addr  = jdx_ff[AW-1:0];
               ram_wdata = ram_rdata;
               jdx_in    = jdx_ff - 1'b1;
               state_in  = S_SRT_RDJ;
            end else begin
               state_in = S_SRT_PUT;
            end
         end
         S_SRT_PUT: begin
            ram_we    = 1'b1;
            ram_addr  = jdx_ff[AW-1:0];
            ram_wdata = hold_ff;
            idx_in    = idx_ff + 1'b1;
            state_in  = S_SRT_RDI;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase

      // Counter saturates by holding its top bit.
      if (cmp_in[16]) begin
         cmp_in = 17'h1_0000;
      end
   end

   // Outputs.
   always_comb begin
      busy                 = (state_ff != S_IDLE);
      rsp_valid            = (state_ff == S_DONE);
      rsp_status           = status_ff;
      rsp_found_count      = found_ff;
      rsp_entry_total      = 9'(count_ff);
      rsp_size_now         = 9'(size_ff);
      rsp_comparison_count = cmp_ff[16] ? 16'hFFFF : cmp_ff[15:0];
   end

   // Checks.
   a_count_le_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("entry count above capacity");
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("response strobe held");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(op_ff) == OP_CLEAR && op_ff == OP_CLEAR)
      |-> rsp_entry_total == '0) else $error("clear left entries");

endmodule : keyed_record_table
`default_nettype wire
